>>> hdl/s256_pkg.sv
package s256_pkg;

  typedef logic [31:0] word_t;

  // working variables / chaining value, index 0 is a (or H0)
  typedef logic [0:7][31:0] work_t;

  localparam int unsigned BlockBits = 512;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenStart = 56;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam work_t H_INIT = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> hdl/s256_round.sv
module s256_round (
  input  s256_pkg::work_t      cur,
  input  logic [511:0]         sched,
  input  logic [5:0]           rnd,
  output s256_pkg::work_t      nxt,
  output s256_pkg::word_t      w_new
);
  import s256_pkg::*;

  word_t w0, w1, w9, w14;
  word_t s0, s1;
  word_t big_s0, big_s1, ch, maj, t1, t2;

  // schedule window, oldest word at the top
  assign w0  = sched[511:480];
  assign w1  = sched[479:448];
  assign w9  = sched[223:192];
  assign w14 = sched[63:32];

  // next schedule word, w[t+16]
  assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  // one compression round
  assign big_s1 = rotr(cur[4], 6) ^ rotr(cur[4], 11) ^ rotr(cur[4], 25);
  assign ch     = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
  assign big_s0 = rotr(cur[0], 2) ^ rotr(cur[0], 13) ^ rotr(cur[0], 22);
  assign maj    = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);
  assign t1     = cur[7] + big_s1 + ch + K_TAB[rnd] + w0;
  assign t2     = big_s0 + maj;

  assign nxt = '{t1 + t2, cur[0], cur[1], cur[2], cur[3] + t1, cur[4], cur[5], cur[6]};

endmodule

>>> hdl/sha256_stream_hasher_top.sv
// byte request: the 64th byte of a block starts a compression
// (64 rounds on the shared round unit, then the chaining add), not ready meanwhile
// end-of-message request: up to 72 padding bytes, one or two compressions, then eight
// digest words, one per output handshake
// reset: synchronous, loads the initial hash values and clears counts and sequencer
module sha256_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import s256_pkg::*;

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;  // taking message bytes
  localparam logic [2:0] ST_PAD  = 3'd1;  // shifting in 0x80, zeros and the bit length
  localparam logic [2:0] ST_RUN  = 3'd2;  // compression rounds
  localparam logic [2:0] ST_FIN  = 3'd3;  // add working variables into the chaining value
  localparam logic [2:0] ST_OUT  = 3'd4;  // hand out the digest words

  logic [2:0]   state;
  logic [5:0]   fill;        // bytes held in the current block
  logic [60:0]  msg;         // message length in bytes, wraps
  work_t        chain;       // chaining value
  work_t        work;        // working variables a..h
  logic [511:0] sched;       // block buffer, reused as the schedule window
  logic [5:0]   rnd;         // round counter
  logic [2:0]   widx;        // digest word being handed out
  logic         pad_act;     // padding underway for this message
  logic         pad_first;   // next padding byte is the 0x80 mark
  logic         len_blk;     // this block carries the bit length

  work_t        rnd_nxt;
  word_t        w_new;
  logic [63:0]  len_bits;
  logic [7:0]   len_byte;
  logic [7:0]   pad_byte;
  logic         full_in;

  s256_round u_round (
    .cur   (work),
    .sched (sched),
    .rnd   (rnd),
    .nxt   (rnd_nxt),
    .w_new (w_new)
  );

  // big-endian bit length, byte picked by the low bits of the fill count
  assign len_bits = {msg, 3'b000};
  assign len_byte = 8'(len_bits >> {~fill[2:0], 3'b000});

  always_comb begin
    if (pad_first) begin
      pad_byte = PAD_MARK;
    end else if (len_blk && (fill >= 6'(LenStart))) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // a byte that completes the block
  assign full_in = (fill == 6'(BlockBytes - 1));

  assign in_ready    = (state == ST_IDLE);
  assign out_valid   = (state == ST_OUT);
  assign digest_word = chain[widx];
  assign word_index  = widx;
  assign last_word   = (widx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      msg       <= '0;
      chain     <= H_INIT;
      rnd       <= '0;
      widx      <= '0;
      pad_act   <= 1'b0;
      pad_first <= 1'b0;
      len_blk   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (has_byte) begin
              sched <= {sched[BlockBits-9:0], data_byte};
              fill  <= fill + 6'd1;
              msg   <= msg + 61'd1;
              if (full_in) begin
                state <= ST_RUN;
                work  <= chain;
                rnd   <= '0;
              end
            end
            if (end_of_message) begin
              pad_act   <= 1'b1;
              pad_first <= 1'b1;
              // a full block is compressed before padding starts
              if (!(has_byte && full_in)) begin
                state <= ST_PAD;
              end
            end
          end
        end
        ST_PAD: begin
          sched     <= {sched[BlockBits-9:0], pad_byte};
          fill      <= fill + 6'd1;
          pad_first <= 1'b0;
          if (pad_first) begin
            // no room for the length after the mark: it goes in a fresh block
            len_blk <= (fill < 6'(LenStart));
          end
          if (full_in) begin
            state <= ST_RUN;
            work  <= chain;
            rnd   <= '0;
          end
        end
        ST_RUN: begin
          work  <= rnd_nxt;
          sched <= {sched[BlockBits-33:0], w_new};
          rnd   <= rnd + 6'd1;
          if (rnd == 6'(BlockBytes - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          if (pad_act && !pad_first && len_blk) begin
            state <= ST_OUT;
            widx  <= '0;
          end else if (pad_act) begin
            state   <= ST_PAD;
            len_blk <= 1'b1;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            widx <= widx + 3'd1;
            if (last_word) begin
              // ready for the next message
              state   <= ST_IDLE;
              chain   <= H_INIT;
              fill    <= '0;
              msg     <= '0;
              pad_act <= 1'b0;
              len_blk <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> dv/tb_sha256_stream_hasher_top.sv
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_top;

  // one digest word as it should leave the block
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } due_word_t;

  // eight digest words, word 0 in the top bits
  typedef logic [0:7][31:0] digest_t;

  // directed request: lead bytes of random content go ahead of the request itself
  typedef struct packed {
    logic [7:0] lead;
    logic [7:0] data;
    logic       has;
    logic       eom;
    logic       known;
    digest_t    digest;
  } stim_row_t;

  localparam digest_t EMPTY_DIGEST =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam digest_t ABC_DIGEST =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  localparam int HoldCycles = 400;
  localparam int DrainCycles = 300;

  // own copy of the round constants and initial hash values
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_CHAIN [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // directed table: known digests only for the empty string and "abc"
  localparam int StimRows = 14;
  localparam stim_row_t STIM_TAB [StimRows] = '{
    // empty message straight after reset
    '{8'd0,  8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
    // idle request, must be ignored
    '{8'd0,  8'hff, 1'b0, 1'b0, 1'b0, '0},
    // "abc", last byte together with the end
    '{8'd0,  8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'd0,  8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'd0,  8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
    // single all-ones byte with the end
    '{8'd0,  8'hff, 1'b1, 1'b1, 1'b0, '0},
    // zero byte, idle in the middle of a message, then end with no byte
    '{8'd0,  8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'd0,  8'ha5, 1'b0, 1'b0, 1'b0, '0},
    '{8'd0,  8'h00, 1'b0, 1'b1, 1'b0, '0},
    // 55 bytes: marker and length just fit in one block
    '{8'd54, 8'h5a, 1'b1, 1'b1, 1'b0, '0},
    // 56 bytes: padding spills into a second block
    '{8'd55, 8'hc3, 1'b1, 1'b1, 1'b0, '0},
    // 62 bytes, end on its own, spills too
    '{8'd62, 8'h00, 1'b0, 1'b1, 1'b0, '0},
    // 64 bytes: the last byte fills a block, then a padding-only block
    '{8'd63, 8'h7f, 1'b1, 1'b1, 1'b0, '0},
    // empty again, proves the chain was re-initialised
    '{8'd0,  8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // predictor state
  logic [31:0] chain_pred [8];
  logic [7:0]  blk_pred [64];
  int unsigned fill_pred;
  logic [60:0] msg_len_pred;

  due_word_t digest_due_q [$];

  int  errors = 0;
  int  requests_sent = 0;
  int  messages_sent = 0;
  int  words_checked = 0;
  bit  steady = 1'b0;     // no idling on either side
  bit  hold_req = 1'b0;   // asks the receiver for its long hold-off
  bit  hold_done = 1'b0;

  sha256_stream_hasher_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_chain();
    for (int i = 0; i < 8; i++) chain_pred[i] = START_CHAIN[i];
    fill_pred = 0;
    msg_len_pred = '0;
  endfunction

  // one 64-round compression of blk_pred into chain_pred
  function automatic void compress_pred();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_pred[4*i], blk_pred[4*i+1], blk_pred[4*i+2], blk_pred[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain_pred[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_pred[i] = chain_pred[i] + v[i];
  endfunction

  // absorbs one request; returns 1 with the digest when the message ends
  function automatic bit hash_request(input logic [7:0] d, input logic h, input logic e,
                                      output digest_t dg);
    logic [63:0] nbits;
    dg = '0;
    if (h) begin
      blk_pred[fill_pred] = d;
      fill_pred++;
      msg_len_pred = msg_len_pred + 61'd1;
      if (fill_pred == 64) begin
        compress_pred();
        fill_pred = 0;
      end
    end
    if (!e) return 1'b0;
    nbits = {msg_len_pred, 3'b000};
    blk_pred[fill_pred] = 8'h80;
    fill_pred++;
    // marker leaves no room for the length: close this block first
    if (fill_pred > 56) begin
      while (fill_pred < 64) begin
        blk_pred[fill_pred] = 8'h00;
        fill_pred++;
      end
      compress_pred();
      fill_pred = 0;
    end
    while (fill_pred < 56) begin
      blk_pred[fill_pred] = 8'h00;
      fill_pred++;
    end
    for (int i = 0; i < 8; i++) blk_pred[56+i] = nbits[63-8*i -: 8];
    compress_pred();
    for (int i = 0; i < 8; i++) dg[i] = chain_pred[i];
    restart_chain();
    return 1'b1;
  endfunction

  // drive one request, wait for its handshake, then queue what it should produce
  task automatic offer(input logic [7:0] d, input logic h, input logic e,
                       input logic known, input digest_t typed);
    digest_t dg;
    if (!steady && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_valid       <= 1'b1;
    data_byte      <= d;
    has_byte       <= h;
    end_of_message <= e;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    if (hash_request(d, h, e, dg)) begin
      // typed digests take the place of the predicted ones
      if (known) dg = typed;
      for (int i = 0; i < 8; i++)
        digest_due_q.push_back('{dg[i], 3'(i), (i == 7)});
      messages_sent++;
    end
  endtask

  // result checker: compares every accepted word with the oldest expectation
  always @(posedge clk) begin : check_words
    due_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (digest_due_q.size() == 0) begin
        $error("digest word %h arrived with nothing expected", digest_word);
        errors++;
      end else begin
        want = digest_due_q.pop_front();
        words_checked++;
        if (digest_word !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, digest_word);
          errors++;
        end
        if (word_index !== want.index) begin
          $error("word_index: expected %0d, got %0d", want.index, word_index);
          errors++;
        end
        if (last_word !== want.last) begin
          $error("last_word: expected %0b, got %0b", want.last, last_word);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off on request from the stimulus side
  initial begin
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_done = 1'b1;
        // sender keeps offering meanwhile, so the block backs up and stalls its input
        for (int n = 0; n < HoldCycles; n++) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 16);
      end
    end
  end

  // main stimulus
  initial begin : stimulus
    int len;
    int pick;
    int fold;
    int msg_no;
    int rand_requests;
    for (int i = 0; i < 64; i++) blk_pred[i] = 8'h00;
    restart_chain();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part, walked row by row; the long boundary rows run with no idling
    for (int r = 0; r < StimRows; r++) begin
      steady = (r >= 9 && r <= 12);
      for (int k = 0; k < STIM_TAB[r].lead; k++)
        offer(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, '0);
      offer(STIM_TAB[r].data, STIM_TAB[r].has, STIM_TAB[r].eom,
            STIM_TAB[r].known, STIM_TAB[r].digest);
    end
    steady = 1'b0;

    // random messages: mostly short, a good share near the block boundary, a few long
    msg_no = 0;
    rand_requests = 0;
    while (rand_requests < 110 || msg_no < 4) begin
      if (msg_no == 1) hold_req = 1'b1;
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(12);
      else if (pick < 90) len = $urandom_range(70, 50);
      else len = $urandom_range(100);
      fold = (len > 0) ? $urandom_range(1) : 0;
      for (int k = 0; k < len - fold; k++) begin
        // scattered idle requests as noise
        if ($urandom_range(99) < 8)
          offer(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
        offer(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, '0);
        rand_requests++;
      end
      if (fold != 0) offer(8'($urandom_range(255)), 1'b1, 1'b1, 1'b0, '0);
      else offer(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
      rand_requests++;
      msg_no++;
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // drain, then give stray words a chance to show up
    while (digest_due_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d requests in %0d messages, %0d digest words compared",
             requests_sent, messages_sent, words_checked);
    $display("incl. empty and known messages, padding spill-over and long receiver hold-off");
    if (errors == 0) begin
      $display("tb_sha256_stream_hasher_top passed");
    end else begin
      $display("tb_sha256_stream_hasher_top failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("tb_sha256_stream_hasher_top failed");
    $finish;
  end

endmodule
